// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/masg_pkg.sv
package masg_pkg;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_READ       = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MIN_GAP      = 2'd0,
        REG_CLAMP_MAX    = 2'd1,
        REG_DIR_POLARITY = 2'd2
    } reg_index_t;

    localparam logic [15:0] MIN_GAP_RESET      = 16'd500;
    localparam logic [15:0] CLAMP_MAX_RESET    = 16'd4095;
    localparam logic [7:0]  DIR_POLARITY_RESET = 8'd0;
    localparam logic [15:0] TICK_MAX           = 16'hFFFF;

    typedef struct packed {
        logic tick;
        logic load;
    } axis_ctrl_t;

    typedef struct packed {
        logic step;
        logic dir;
    } axis_stat_t;

endpackage

// File: hdl/masg_if.sv
interface masg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  axis_index;
    logic signed [16:0] target_request;

    modport source (output valid, command, axis_index, target_request, input ready);
    modport sink   (input valid, command, axis_index, target_request, output ready);
endinterface

interface masg_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  step_mask;
    logic [7:0]  dir_levels;
    logic [15:0] read_position;
    logic [15:0] read_target;
    logic        index_valid;

    modport source (output valid, step_mask, dir_levels, read_position, read_target,
                    index_valid, input ready);
    modport sink   (input valid, step_mask, dir_levels, read_position, read_target,
                    index_valid, output ready);
endinterface

// File: hdl/multi_axis_stepper_step_generator.sv
// Channel | Dir | Payload                                                  | Transfer
// cmd     | in  | command, axis_index, target_request                      | valid & ready
// rsp     | out | step_mask, dir_levels, read_position, read_target,       | valid & ready
//         |     | index_valid                                              |
// cfg     | in  | cfg_index, cfg_data                                      | cfg_we
//
// One item per clock sustained while rsp takes each result. A transfer on cmd lands in
// the input register; once the result register is free, all axis lanes update together
// and the result register loads, raising rsp.valid. Throughput is set by the single
// update stage shared by all lanes. A stalled rsp holds the result register and, one
// item later, the input register; cmd.ready drops only when both are full.
// rst_n clears all axis state and restores register defaults at once.
`include "assert_macros.svh"

module multi_axis_stepper_step_generator
    import masg_pkg::*;
#(
    parameter int AXIS_COUNT    = 5,
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    masg_cmd_if.sink    cmd,
    masg_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // largest position value, seen through the 16-bit clamp bound
    localparam logic [15:0] POS_LIMIT = (POSITION_BITS >= 16) ? 16'hFFFF :
                                        16'((32'd1 << POSITION_BITS) - 32'd1);

    // configuration
    logic [15:0] min_gap_reg;
    logic [15:0] clamp_max_reg;
    logic [7:0]  dir_polarity_reg;

    // input register
    logic               in_valid_reg;
    logic [1:0]         command_reg;
    logic [3:0]         index_reg;
    logic signed [16:0] request_reg;

    // result register
    logic        rsp_valid_reg;
    logic [7:0]  step_mask_reg, step_mask_next;
    logic [7:0]  dir_levels_reg, dir_levels_next;
    logic [15:0] read_position_reg, read_position_next;
    logic [15:0] read_target_reg, read_target_next;
    logic        index_valid_reg, index_valid_next;

    logic advance;
    logic fire;
    logic is_tick;
    logic is_set;
    logic is_read;

    // clamp of the requested target
    logic [15:0]              clamp_bound;
    logic [15:0]              clamp_value;
    logic [POSITION_BITS-1:0] load_value;

    axis_ctrl_t               lane_ctrl [AXIS_COUNT];
    axis_stat_t               lane_stat [AXIS_COUNT];
    logic [POSITION_BITS-1:0] lane_pos  [AXIS_COUNT];
    logic [POSITION_BITS-1:0] lane_tgt  [AXIS_COUNT];

    // ---------------------------------------------------------------- handshake
    // Result register frees when empty or taken; input register moves on then.
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            command_reg <= cmd.command;
            index_reg   <= cmd.axis_index;
            request_reg <= cmd.target_request;
        end
        if (fire)
        begin
            step_mask_reg     <= step_mask_next;
            dir_levels_reg    <= dir_levels_next;
            read_position_reg <= read_position_next;
            read_target_reg   <= read_target_next;
            index_valid_reg   <= index_valid_next;
        end
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg      <= MIN_GAP_RESET;
            clamp_max_reg    <= CLAMP_MAX_RESET;
            dir_polarity_reg <= DIR_POLARITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_GAP:      min_gap_reg      <= cfg_data;
                REG_CLAMP_MAX:    clamp_max_reg    <= cfg_data;
                REG_DIR_POLARITY: dir_polarity_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        is_tick = 1'b0;
        is_set  = 1'b0;
        is_read = 1'b0;
        unique case (cmd_t'(command_reg))
            CMD_TICK:       is_tick = 1'b1;
            CMD_SET_TARGET: is_set  = 1'b1;
            CMD_READ:       is_read = 1'b1;
            default:        ;   // reserved code: no state change
        endcase
    end

    assign index_valid_next = index_reg < 4'(AXIS_COUNT);

    // negative requests go to zero, large ones to the tighter of the two bounds
    assign clamp_bound = (clamp_max_reg > POS_LIMIT) ? POS_LIMIT : clamp_max_reg;
    assign clamp_value = request_reg[16] ? 16'd0 :
                         ((request_reg[15:0] > clamp_bound) ? clamp_bound : request_reg[15:0]);
    assign load_value  = POSITION_BITS'(clamp_value);

    // ---------------------------------------------------------------- lanes
    for (genvar i = 0; i < AXIS_COUNT; i++)
    begin : g_axis
        assign lane_ctrl[i].tick = fire && is_tick;
        assign lane_ctrl[i].load = fire && is_set && (index_reg == 4'(i));

        masg_axis #(
            .POSITION_BITS (POSITION_BITS)
        ) u_axis (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl[i]),
            .min_gap    (min_gap_reg),
            .polarity   (dir_polarity_reg[i]),
            .load_value (load_value),
            .stat       (lane_stat[i]),
            .position   (lane_pos[i]),
            .target     (lane_tgt[i])
        );
    end

    // result gather; unused mask and level bits stay low
    always_comb
    begin
        step_mask_next     = '0;
        dir_levels_next    = '0;
        read_position_next = '0;
        read_target_next   = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            step_mask_next[i]  = lane_stat[i].step;
            dir_levels_next[i] = lane_stat[i].dir;
            if (is_read && (index_reg == 4'(i)))
            begin
                read_position_next = 16'(lane_pos[i]);
                read_target_next   = 16'(lane_tgt[i]);
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.step_mask     = step_mask_reg;
    assign rsp.dir_levels    = dir_levels_reg;
    assign rsp.read_position = read_position_reg;
    assign rsp.read_target   = read_target_reg;
    assign rsp.index_valid   = index_valid_reg;

    // ---------------------------------------------------------------- checks
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, in_valid_reg && !advance, !cmd.ready)
    `ASSERT_NEXT(a_step_on_tick_only, clk, rst_n, fire && !is_tick, rsp.step_mask == 8'd0)
    `ASSERT_NEXT(a_read_zero, clk, rst_n, fire && !is_read,
                 rsp.read_position == 16'd0 && rsp.read_target == 16'd0)

endmodule

// File: hdl/masg_axis.sv
module masg_axis
    import masg_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  axis_ctrl_t               ctrl,
    input  logic [15:0]              min_gap,
    input  logic                     polarity,
    input  logic [POSITION_BITS-1:0] load_value,
    output axis_stat_t               stat,
    output logic [POSITION_BITS-1:0] position,
    output logic [POSITION_BITS-1:0] target
);

    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [15:0]              ticks_reg, ticks_next;
    logic                     dir_reg, dir_next;
    logic [15:0]              ticks_inc;
    logic                     move;
    logic                     upward;

    // saturating elapsed count, as seen after this tick
    assign ticks_inc = (ticks_reg != TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign upward    = target_reg > position_reg;
    assign move      = ctrl.tick && (target_reg != position_reg) && (ticks_inc >= min_gap);

    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        ticks_next    = ticks_reg;
        dir_next      = dir_reg;
        if (ctrl.tick)
        begin
            ticks_next = ticks_inc;
        end
        if (move)
        begin
            if (upward)
            begin
                position_next = position_reg + POSITION_BITS'(1);
                dir_next      = polarity;
            end
            else
            begin
                position_next = position_reg - POSITION_BITS'(1);
                dir_next      = ~polarity;
            end
            ticks_next = '0;
        end
        if (ctrl.load)
        begin
            target_next = load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            target_reg   <= '0;
            ticks_reg    <= TICK_MAX;
            dir_reg      <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            target_reg   <= target_next;
            ticks_reg    <= ticks_next;
            dir_reg      <= dir_next;
        end
    end

    assign stat.step = move;
    assign stat.dir  = dir_next;
    assign position  = position_reg;
    assign target    = target_reg;

endmodule

// File: sim/tb_multi_axis_stepper_step_generator.sv
module tb_multi_axis_stepper_step_generator;
    import masg_pkg::*;

    localparam int AXES  = 5;
    localparam int POS_W = 16;

    // Command code 3 is reserved: it must leave all state untouched.
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    // Register index 3 selects nothing; a write there must be ignored.
    localparam logic [1:0] REG_NONE     = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic [3:0]         axis_index;
        logic signed [16:0] target_request;
    } axis_cmd_t;

    typedef struct {
        logic [7:0]  step_mask;
        logic [7:0]  dir_levels;
        logic [15:0] read_position;
        logic [15:0] read_target;
        logic        index_valid;
    } axis_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    masg_cmd_if cmd_ch ();
    masg_rsp_if rsp_ch ();

    multi_axis_stepper_step_generator #(
        .AXIS_COUNT    (AXES),
        .POSITION_BITS (POS_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: shadow copy of the per-axis lanes and the registers.
    logic [POS_W-1:0] lane_pos   [AXES];
    logic [POS_W-1:0] lane_tgt   [AXES];
    logic [15:0]      lane_ticks [AXES];
    logic [AXES-1:0]  lane_dir;
    logic [15:0]      min_gap_q;
    logic [15:0]      clamp_max_q;
    logic [7:0]       dir_pol_q;

    axis_cmd_t    pending_cmds [$];   // items waiting for the driver
    axis_result_t axis_results [$];   // predicted results, oldest first
    axis_cmd_t    cmd_held;           // item currently on the cmd channel

    int cmds_queued;
    int results_seen;
    int failures;
    int idle_max;                     // upper bound of random gaps and stalls
    int cmd_gap;
    int rsp_gap;

    // Clamp a signed request into 0..clamp_max.
    function automatic logic [POS_W-1:0] clamp_request(logic signed [16:0] req);
        if (req[16])
            return '0;
        if (req[15:0] > clamp_max_q)
            return clamp_max_q;
        return req[15:0];
    endfunction

    // Advance the shadow lanes by one accepted command and build its result.
    function automatic axis_result_t predict_axes(axis_cmd_t c);
        axis_result_t r;
        logic         ok;
        r  = '{default: '0};
        ok = (c.axis_index < AXES);
        case (c.command)
            CMD_TICK:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    // elapsed count saturates, then the step test uses the new value
                    if (lane_ticks[i] != TICK_MAX)
                        lane_ticks[i] = lane_ticks[i] + 16'd1;
                    if (lane_tgt[i] != lane_pos[i] && lane_ticks[i] >= min_gap_q)
                    begin
                        if (lane_tgt[i] > lane_pos[i])
                        begin
                            lane_dir[i] = dir_pol_q[i];
                            lane_pos[i] = lane_pos[i] + 1'b1;
                        end
                        else
                        begin
                            lane_dir[i] = ~dir_pol_q[i];
                            lane_pos[i] = lane_pos[i] - 1'b1;
                        end
                        lane_ticks[i]  = '0;
                        r.step_mask[i] = 1'b1;
                    end
                end
            end
            CMD_SET_TARGET:
            begin
                if (ok)
                    lane_tgt[c.axis_index] = clamp_request(c.target_request);
            end
            CMD_READ:
            begin
                if (ok)
                begin
                    r.read_position = lane_pos[c.axis_index];
                    r.read_target   = lane_tgt[c.axis_index];
                end
            end
            default:
            begin
                // reserved: nothing moves
            end
        endcase
        r.dir_levels  = 8'(lane_dir);
        r.index_valid = ok;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endfunction

    function automatic axis_cmd_t make_cmd(logic [1:0] op, logic [3:0] idx,
                                           logic signed [16:0] req);
        axis_cmd_t c;
        c.command        = op;
        c.axis_index     = idx;
        c.target_request = req;
        return c;
    endfunction

    // Random command mix: mostly ticks so the lanes actually move, targets mostly kept
    // small (0..40) so both directions show up, with some full-range
    // and negative requests and a sprinkling of invalid axes and reserved codes.
    function automatic axis_cmd_t random_cmd();
        axis_cmd_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            c.command = CMD_TICK;
        else if (pick < 83)
            c.command = CMD_SET_TARGET;
        else if (pick < 97)
            c.command = CMD_READ;
        else
            c.command = CMD_RESERVED;
        if ($urandom_range(0, 9) == 0)
            c.axis_index = 4'($urandom_range(AXES, 15));
        else
            c.axis_index = 4'($urandom_range(0, AXES - 1));
        case ($urandom_range(0, 9))
            0:       c.target_request = 17'($urandom);
            1:       c.target_request = {1'b1, 16'($urandom)};
            2:       c.target_request = 17'($urandom_range(0, 300));
            default: c.target_request = 17'($urandom_range(0, 40));
        endcase
        return c;
    endfunction

    task automatic queue_cmd(axis_cmd_t c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // Registers change only while nothing is in flight, so the shadow copy is
    // updated right here together with the write.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MIN_GAP:      min_gap_q   = value;
            REG_CLAMP_MAX:    clamp_max_q = value;
            REG_DIR_POLARITY: dir_pol_q   = value[7:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every command yields a result, so the block is idle once the counts meet;
    // the extra wait after that covers the two-stage pipe.
    task automatic wait_drained();
        while (results_seen != cmds_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int count, int gap_max);
        idle_max = gap_max;
        repeat (count) queue_cmd(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: one transfer per accepted cmd item; payload holds while stalled.
    always @(posedge clk)
    begin : drive_cmds
        axis_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_gap      <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                axis_results.push_back(predict_axes(cmd_held));

            if (cmd_ch.valid && !cmd_ch.ready)
            begin
                // stalled: keep the item on the bus
            end
            else if (cmd_gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                cmd_gap      <= cmd_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                nxt = pending_cmds.pop_front();
                cmd_held              <= nxt;
                cmd_ch.command        <= nxt.command;
                cmd_ch.axis_index     <= nxt.axis_index;
                cmd_ch.target_request <= nxt.target_request;
                cmd_ch.valid          <= 1'b1;
                cmd_gap               <= $urandom_range(0, idle_max);
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Monitor: compares each rsp transfer with the oldest prediction, then
    // draws a stall before the next one.
    always @(posedge clk)
    begin : collect_results
        axis_result_t want;
        int           hold;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= 0;
        end
        else
        begin
            hold = rsp_gap;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (axis_results.size() == 0)
                begin
                    $error("result transfer with no prediction pending");
                    failures++;
                end
                else
                begin
                    want = axis_results.pop_front();
                    check_field("step_mask", want.step_mask, rsp_ch.step_mask);
                    check_field("dir_levels", want.dir_levels, rsp_ch.dir_levels);
                    check_field("read_position", want.read_position, rsp_ch.read_position);
                    check_field("read_target", want.read_target, rsp_ch.read_target);
                    check_field("index_valid", want.index_valid, rsp_ch.index_valid);
                end
                hold = $urandom_range(0, idle_max);
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_gap      <= hold - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rsp_gap      <= 0;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = '0;
        cmd_ch.axis_index     = '0;
        cmd_ch.target_request = '0;
        rsp_ch.ready          = 1'b0;
        cmds_queued           = 0;
        results_seen          = 0;
        failures              = 0;
        idle_max              = 6;

        // shadow state after reset: counters start saturated
        min_gap_q   = MIN_GAP_RESET;
        clamp_max_q = CLAMP_MAX_RESET;
        dir_pol_q   = DIR_POLARITY_RESET;
        lane_dir    = '0;
        for (int i = 0; i < AXES; i++)
        begin
            lane_pos[i]   = '0;
            lane_tgt[i]   = '0;
            lane_ticks[i] = TICK_MAX;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset values, invalid axes, clamp edges, reserved code,
        // the first step out of saturated counters, then the default delay.
        queue_cmd(make_cmd(CMD_READ, 4'd0, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd4, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd5, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd15, 17'sd0));
        queue_cmd(make_cmd(CMD_TICK, 4'd15, -17'sd1));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd0, 17'sd65535));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd1, -17'sd65536));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd2, 17'sd10));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd4, 17'sd4095));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd3, 17'sd4096));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd7, 17'sd3));
        queue_cmd(make_cmd(CMD_RESERVED, 4'd1, 17'sd5));
        queue_cmd(make_cmd(CMD_READ, 4'd0, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd3, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd7, 17'sd0));
        queue_cmd(make_cmd(CMD_TICK, 4'd0, 17'sd0));
        queue_cmd(make_cmd(CMD_TICK, 4'd0, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd2, 17'sd0));
        queue_cmd(make_cmd(CMD_SET_TARGET, 4'd0, 17'sd0));
        queue_cmd(make_cmd(CMD_TICK, 4'd3, 17'sd0));
        queue_cmd(make_cmd(CMD_READ, 4'd0, 17'sd0));
        wait_drained();

        // Delay 0 with the widest clamp and every polarity bit (upper bits too).
        write_reg(REG_MIN_GAP, 16'd0);
        write_reg(REG_CLAMP_MAX, 16'hFFFF);
        write_reg(REG_DIR_POLARITY, 16'hFFFF);
        write_reg(REG_NONE, 16'hA5A5);
        run_random(80, 6);

        // Delay 1, all targets forced to zero, mixed polarity, no idling.
        write_reg(REG_MIN_GAP, 16'd1);
        write_reg(REG_CLAMP_MAX, 16'd0);
        write_reg(REG_DIR_POLARITY, 16'($urandom_range(0, 255)));
        run_random(70, 0);

        // Short delays and a tight clamp so lanes hit their targets often.
        write_reg(REG_MIN_GAP, 16'($urandom_range(2, 4)));
        write_reg(REG_CLAMP_MAX, 16'd20);
        write_reg(REG_DIR_POLARITY, 16'h0015);
        run_random(90, 6);

        // Longest delay: only lanes still saturated can step.
        write_reg(REG_MIN_GAP, 16'hFFFF);
        write_reg(REG_CLAMP_MAX, 16'($urandom_range(1, 65534)));
        write_reg(REG_DIR_POLARITY, 16'd0);
        run_random(50, 3);

        // Delay 1 again with a random clamp and polarity, first without idling, then with.
        write_reg(REG_MIN_GAP, 16'd1);
        write_reg(REG_CLAMP_MAX, 16'($urandom_range(30, 4000)));
        write_reg(REG_DIR_POLARITY, 16'($urandom_range(0, 255)));
        run_random(60, 0);
        run_random(60, 6);

        repeat (10) @(posedge clk);
        if (axis_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", axis_results.size());
            failures++;
        end
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (a few hundred items, each with its
    // random idle and stall gaps bounded by idle_max, plus the pipe).
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/masg_pkg.sv
hdl/masg_if.sv
hdl/masg_axis.sv
hdl/multi_axis_stepper_step_generator.sv
sim/tb_multi_axis_stepper_step_generator.sv
